// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the predictor.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define TBP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("predictor assertion failed");

// Checked on every rising edge, reset included.
`define TBP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("predictor assertion failed");

`endif

// File: src/tbp_pkg.sv
// ---------------------------------------------------------------------------
// Tournament branch predictor package
// Counter type, table defaults, memory control struct and counter helpers.
// ---------------------------------------------------------------------------
package tbp_pkg;

    typedef logic [1:0] t_ctr;

    localparam t_ctr CTR_RESET = 2'd2;
    localparam t_ctr CTR_MAX   = 2'd3;
    localparam t_ctr CTR_MIN   = 2'd0;

    localparam int GSHARE_ENTRIES_DEF  = 4096;
    localparam int BIMODAL_ENTRIES_DEF = 1024;
    localparam int CHOOSER_ENTRIES_DEF = 4096;
    localparam int HISTORY_BITS_DEF    = 6;

    localparam int PC_W = 32;

    // Read enable, write enable and write data of one counter memory.
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        t_ctr wr_data;
    } t_ram_ctl;

    // Saturating move of a two-bit counter.
    function automatic t_ctr ctr_train(input t_ctr c, input logic up);
        t_ctr res;
        if (up) begin
            res = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
        end else begin
            res = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
        end
        return res;
    endfunction

    // Upper half of the range means taken (or, for the chooser, bimodal).
    function automatic logic ctr_high(input t_ctr c);
        return c[1];
    endfunction

endpackage

// File: src/tbp_ctr_ram.sv
// ---------------------------------------------------------------------------
// Counter memory
// One table of two-bit counters: one write port, one registered read port.
// ---------------------------------------------------------------------------
module tbp_ctr_ram #(
    parameter int DEPTH = tbp_pkg::GSHARE_ENTRIES_DEF
) (
    input  logic                     i_clk,
    input  tbp_pkg::t_ram_ctl        i_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    output tbp_pkg::t_ctr            o_rd_data
);
    import tbp_pkg::*;

    t_ctr r_mem [DEPTH];
    t_ctr r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_ctl.wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/tbp_ctrl.sv
// ---------------------------------------------------------------------------
// Predictor control
// Clearing pass, index forming, prediction, training and global history.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tbp_ctrl #(
    parameter int GSHARE_ENTRIES  = tbp_pkg::GSHARE_ENTRIES_DEF,
    parameter int BIMODAL_ENTRIES = tbp_pkg::BIMODAL_ENTRIES_DEF,
    parameter int CHOOSER_ENTRIES = tbp_pkg::CHOOSER_ENTRIES_DEF,
    parameter int HISTORY_BITS    = tbp_pkg::HISTORY_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic [tbp_pkg::PC_W-1:0]           i_pc,
    input  logic                               i_taken,
    output tbp_pkg::t_ram_ctl                  o_g_ctl,
    output logic [$clog2(GSHARE_ENTRIES)-1:0]  o_g_rd_addr,
    output logic [$clog2(GSHARE_ENTRIES)-1:0]  o_g_wr_addr,
    input  tbp_pkg::t_ctr                      i_g_rd_data,
    output tbp_pkg::t_ram_ctl                  o_b_ctl,
    output logic [$clog2(BIMODAL_ENTRIES)-1:0] o_b_rd_addr,
    output logic [$clog2(BIMODAL_ENTRIES)-1:0] o_b_wr_addr,
    input  tbp_pkg::t_ctr                      i_b_rd_data,
    output tbp_pkg::t_ram_ctl                  o_c_ctl,
    output logic [$clog2(CHOOSER_ENTRIES)-1:0] o_c_rd_addr,
    output logic [$clog2(CHOOSER_ENTRIES)-1:0] o_c_wr_addr,
    input  tbp_pkg::t_ctr                      i_c_rd_data,
    output logic                               o_result_valid,
    output logic                               o_predicted_taken,
    output logic                               o_used_bimodal,
    output logic                               o_mispredicted
);
    import tbp_pkg::*;

    localparam int GW      = $clog2(GSHARE_ENTRIES);
    localparam int BW      = $clog2(BIMODAL_ENTRIES);
    localparam int CW      = $clog2(CHOOSER_ENTRIES);
    localparam int GB_MAX  = (GSHARE_ENTRIES > BIMODAL_ENTRIES) ? GSHARE_ENTRIES
                                                                 : BIMODAL_ENTRIES;
    localparam int MAX_ENT = (GB_MAX > CHOOSER_ENTRIES) ? GB_MAX : CHOOSER_ENTRIES;
    localparam int CLR_W   = $clog2(MAX_ENT);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD
    } t_state;

    t_state                  r_state, n_state;
    logic [CLR_W-1:0]        r_clr_idx, n_clr_idx;
    logic [HISTORY_BITS-1:0] r_hist, n_hist;
    logic [GW-1:0]           r_gidx, n_gidx;
    logic [BW-1:0]           r_bidx, n_bidx;
    logic [CW-1:0]           r_cidx, n_cidx;
    logic                    r_taken, n_taken;
    logic                    r_valid, n_valid;
    logic                    r_pred, n_pred;
    logic                    r_used_bim, n_used_bim;
    logic                    r_mis, n_mis;

    logic                    accept;
    logic                    clearing;
    logic                    use_bim;
    logic                    pred;
    logic                    correct;
    logic [PC_W-1:0]         hist_ext;

    assign accept   = i_start && (r_state == S_IDLE);
    assign clearing = (r_state == S_CLEAR);
    assign hist_ext = PC_W'(r_hist);

    // Prediction from the counters read for the request in flight.
    assign use_bim = ctr_high(i_c_rd_data);
    assign pred    = use_bim ? ctr_high(i_b_rd_data) : ctr_high(i_g_rd_data);
    assign correct = (pred == r_taken);

    always_comb begin
        n_state    = r_state;
        n_clr_idx  = r_clr_idx;
        n_hist     = r_hist;
        n_gidx     = r_gidx;
        n_bidx     = r_bidx;
        n_cidx     = r_cidx;
        n_taken    = r_taken;
        n_valid    = 1'b0;
        n_pred     = r_pred;
        n_used_bim = r_used_bim;
        n_mis      = r_mis;
        case (r_state)
            S_CLEAR: begin
                n_clr_idx = r_clr_idx + CLR_W'(1);
                if (r_clr_idx == CLR_W'(MAX_ENT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_gidx  = GW'(i_pc ^ hist_ext);
                    n_bidx  = i_pc[BW-1:0];
                    n_cidx  = i_pc[CW-1:0];
                    n_taken = i_taken;
                    n_hist  = HISTORY_BITS'({r_hist, i_taken});
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_valid    = 1'b1;
                n_pred     = pred;
                n_used_bim = use_bim;
                n_mis      = !correct;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_hist    <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_hist    <= n_hist;
            r_valid   <= n_valid;
        end
        r_gidx     <= n_gidx;
        r_bidx     <= n_bidx;
        r_cidx     <= n_cidx;
        r_taken    <= n_taken;
        r_pred     <= n_pred;
        r_used_bim <= n_used_bim;
        r_mis      <= n_mis;
    end

    // Memory control: read on accept, write back in the update cycle, write the reset value while clearing.
    always_comb begin
        o_g_ctl.rd_en   = accept;
        o_b_ctl.rd_en   = accept;
        o_c_ctl.rd_en   = accept;
        o_g_ctl.wr_en   = clearing || (r_state == S_UPD);
        o_b_ctl.wr_en   = clearing || (r_state == S_UPD);
        o_c_ctl.wr_en   = clearing || (r_state == S_UPD);
        o_g_ctl.wr_data = clearing ? CTR_RESET : ctr_train(i_g_rd_data, r_taken);
        o_b_ctl.wr_data = clearing ? CTR_RESET : ctr_train(i_b_rd_data, r_taken);
        o_c_ctl.wr_data = clearing ? CTR_RESET : ctr_train(i_c_rd_data, use_bim == correct);
    end

    assign o_g_rd_addr = GW'(i_pc ^ hist_ext);
    assign o_b_rd_addr = i_pc[BW-1:0];
    assign o_c_rd_addr = i_pc[CW-1:0];
    assign o_g_wr_addr = clearing ? r_clr_idx[GW-1:0] : r_gidx;
    assign o_b_wr_addr = clearing ? r_clr_idx[BW-1:0] : r_bidx;
    assign o_c_wr_addr = clearing ? r_clr_idx[CW-1:0] : r_cidx;

    assign o_busy            = (r_state != S_IDLE);
    assign o_result_valid    = r_valid;
    assign o_predicted_taken = r_pred;
    assign o_used_bimodal    = r_used_bim;
    assign o_mispredicted    = r_mis;

    `TBP_ASSERT(a_valid_after_upd, i_clk, i_rst_n, r_valid |-> $past(r_state == S_UPD))
    `TBP_ASSERT(a_accept_to_upd, i_clk, i_rst_n, accept |=> (r_state == S_UPD))
    `TBP_ASSERT(a_hist_only_on_accept, i_clk, i_rst_n, !accept |=> $stable(r_hist))
    `TBP_ASSERT(a_no_result_in_clear, i_clk, i_rst_n, clearing |-> !r_valid)

endmodule

// File: src/tournament_branch_predictor.sv
// ---------------------------------------------------------------------------
// Tournament branch predictor
// Gshare and bimodal counter tables with a per-branch chooser table.
// ---------------------------------------------------------------------------
// Each request is one resolved branch (address and actual outcome). It is
// taken at a rising edge where start is high and busy is low. The three
// counter tables are synchronous memories with a registered read port: each
// request reads its counters in the accept cycle, and in the following
// cycle, the update state, writes the trained values back and registers the
// prediction made before training. That prediction is then on the result
// ports, marked by o_result_valid for a single cycle. The receiver cannot
// hold it off, so it must sample the result in that cycle. Busy stays high
// through the update state, so a new request is taken only after the last
// one has written its counters back. After reset, busy stays high for a
// clearing pass over max(GSHARE_ENTRIES, BIMODAL_ENTRIES, CHOOSER_ENTRIES)
// addresses (4096 with the defaults) that sets every counter to weakly
// taken. Table sizes are powers of two; the tables are indexed by the low
// address bits, the gshare table by those bits XORed with the global
// history as it stood before the branch.
// ---------------------------------------------------------------------------
module tournament_branch_predictor #(
    parameter int GSHARE_ENTRIES  = tbp_pkg::GSHARE_ENTRIES_DEF,
    parameter int BIMODAL_ENTRIES = tbp_pkg::BIMODAL_ENTRIES_DEF,
    parameter int CHOOSER_ENTRIES = tbp_pkg::CHOOSER_ENTRIES_DEF,
    parameter int HISTORY_BITS    = tbp_pkg::HISTORY_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [tbp_pkg::PC_W-1:0] i_pc,
    input  logic                     i_taken,
    output logic                     o_result_valid,
    output logic                     o_predicted_taken,
    output logic                     o_used_bimodal,
    output logic                     o_mispredicted
);
    import tbp_pkg::*;

    localparam int GW = $clog2(GSHARE_ENTRIES);
    localparam int BW = $clog2(BIMODAL_ENTRIES);
    localparam int CW = $clog2(CHOOSER_ENTRIES);

    // Per-table memory control from the controller.
    t_ram_ctl g_ctl, b_ctl, c_ctl;
    logic [GW-1:0] g_rd_addr, g_wr_addr;
    logic [BW-1:0] b_rd_addr, b_wr_addr;
    logic [CW-1:0] c_rd_addr, c_wr_addr;
    t_ctr          g_rd_data, b_rd_data, c_rd_data;

    tbp_ctrl #(
        .GSHARE_ENTRIES  (GSHARE_ENTRIES),
        .BIMODAL_ENTRIES (BIMODAL_ENTRIES),
        .CHOOSER_ENTRIES (CHOOSER_ENTRIES),
        .HISTORY_BITS    (HISTORY_BITS)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .o_busy            (busy),
        .i_pc              (i_pc),
        .i_taken           (i_taken),
        .o_g_ctl           (g_ctl),
        .o_g_rd_addr       (g_rd_addr),
        .o_g_wr_addr       (g_wr_addr),
        .i_g_rd_data       (g_rd_data),
        .o_b_ctl           (b_ctl),
        .o_b_rd_addr       (b_rd_addr),
        .o_b_wr_addr       (b_wr_addr),
        .i_b_rd_data       (b_rd_data),
        .o_c_ctl           (c_ctl),
        .o_c_rd_addr       (c_rd_addr),
        .o_c_wr_addr       (c_wr_addr),
        .i_c_rd_data       (c_rd_data),
        .o_result_valid    (o_result_valid),
        .o_predicted_taken (o_predicted_taken),
        .o_used_bimodal    (o_used_bimodal),
        .o_mispredicted    (o_mispredicted)
    );

    // Gshare counters, indexed by address XOR global history.
    tbp_ctr_ram #(.DEPTH(GSHARE_ENTRIES)) u_gshare (
        .i_clk     (i_clk),
        .i_ctl     (g_ctl),
        .i_rd_addr (g_rd_addr),
        .i_wr_addr (g_wr_addr),
        .o_rd_data (g_rd_data)
    );

    // Bimodal counters, indexed by address alone.
    tbp_ctr_ram #(.DEPTH(BIMODAL_ENTRIES)) u_bimodal (
        .i_clk     (i_clk),
        .i_ctl     (b_ctl),
        .i_rd_addr (b_rd_addr),
        .i_wr_addr (b_wr_addr),
        .o_rd_data (b_rd_data)
    );

    // Chooser counters: the upper half selects bimodal, the lower half gshare.
    tbp_ctr_ram #(.DEPTH(CHOOSER_ENTRIES)) u_chooser (
        .i_clk     (i_clk),
        .i_ctl     (c_ctl),
        .i_rd_addr (c_rd_addr),
        .i_wr_addr (c_wr_addr),
        .o_rd_data (c_rd_data)
    );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Tournament branch predictor testbench
// Self-checking bench that replays resolved branches and checks every verdict.
// ---------------------------------------------------------------------------
// A queue of branch requests is filled once at time zero. It holds a short
// directed part followed by random branches. A driver takes requests from
// that queue, and a monitor checks the results. Each request is scored
// against the bench's own model of the three counter tables and the global
// history. The model is stepped as each request is accepted, so its
// verdicts are queued in the order in which the block must return them.
// ---------------------------------------------------------------------------
module testbench;

    import tbp_pkg::*;

    localparam int unsigned GSHARE_N  = GSHARE_ENTRIES_DEF;
    localparam int unsigned BIMODAL_N = BIMODAL_ENTRIES_DEF;
    localparam int unsigned CHOOSER_N = CHOOSER_ENTRIES_DEF;
    localparam int unsigned HIST_W    = HISTORY_BITS_DEF;

    // The run is the clearing pass after reset and about 1700 requests,
    // plus the sender's gaps. This limit covers several times that.
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned RANDOM_COUNT = 1680;
    localparam int unsigned HABIT_POOL   = 48;
    // Extra wait at the end so that any stray strobe is still seen.
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [PC_W-1:0] pc;
        logic            taken;
    } t_branch;

    typedef struct packed {
        logic predicted_taken;
        logic used_bimodal;
        logic mispredicted;
    } t_verdict;

    // Behaviours given to the recurring branches of the random part, so
    // that the counters and the chooser are driven through all their states.
    typedef enum logic [2:0] {
        ALWAYS_TAKEN,
        NEVER_TAKEN,
        ALTERNATING,
        LOOP_EXIT,
        BIASED
    } t_habit;

    logic            i_clk   = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start   = 1'b0;
    logic [PC_W-1:0] i_pc    = '0;
    logic            i_taken = 1'b0;
    wire             busy;
    wire             o_result_valid;
    wire             o_predicted_taken;
    wire             o_used_bimodal;
    wire             o_mispredicted;

    // Model state of the predictor.
    t_ctr              gshare_ctrs  [GSHARE_N];
    t_ctr              bimodal_ctrs [BIMODAL_N];
    t_ctr              chooser_ctrs [CHOOSER_N];
    logic [HIST_W-1:0] global_hist;

    t_branch  branch_queue[$];
    t_verdict pending_verdicts[$];

    logic        request_taken  = 1'b0;
    int unsigned total_branches = 0;
    int unsigned issued_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned checked_count  = 0;
    int unsigned mispredict_cnt = 0;
    int unsigned bimodal_cnt    = 0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;

    tournament_branch_predictor u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_pc              (i_pc),
        .i_taken           (i_taken),
        .o_result_valid    (o_result_valid),
        .o_predicted_taken (o_predicted_taken),
        .o_used_bimodal    (o_used_bimodal),
        .o_mispredicted    (o_mispredicted)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Model of the block
    // ------------------------------------------------------------------

    // Two-bit saturating step towards 'up' or away from it.
    function automatic t_ctr saturate_step(input t_ctr c, input logic up);
        if (up) begin
            return (c == CTR_MAX) ? c : t_ctr'(c + 2'd1);
        end
        return (c == CTR_MIN) ? c : t_ctr'(c - 2'd1);
    endfunction

    // Predict one branch from the current tables, then train on its outcome.
    function automatic t_verdict predict_and_train(input logic [PC_W-1:0] pc,
                                                   input logic outcome);
        int unsigned ci;
        int unsigned gi;
        int unsigned bi;
        logic        pick_bimodal;
        logic        guess;
        logic        right;
        t_verdict    v;
        ci = pc % CHOOSER_N;
        // The gshare index uses the history as it stood before this branch.
        gi = (pc ^ PC_W'(global_hist)) % GSHARE_N;
        bi = pc % BIMODAL_N;
        pick_bimodal = chooser_ctrs[ci] >= CTR_RESET;
        guess = pick_bimodal ? (bimodal_ctrs[bi] >= CTR_RESET)
                             : (gshare_ctrs[gi] >= CTR_RESET);
        right = (guess == outcome);
        // The chooser leans towards bimodal when it picked bimodal and was right,
        // or picked gshare and was wrong. Otherwise it leans towards gshare.
        chooser_ctrs[ci] = saturate_step(chooser_ctrs[ci], pick_bimodal == right);
        gshare_ctrs[gi]  = saturate_step(gshare_ctrs[gi], outcome);
        bimodal_ctrs[bi] = saturate_step(bimodal_ctrs[bi], outcome);
        global_hist      = {global_hist[HIST_W-2:0], outcome};
        v.predicted_taken = guess;
        v.used_bimodal    = pick_bimodal;
        v.mispredicted    = !right;
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic queue_branch(input logic [PC_W-1:0] pc, input logic outcome);
        t_branch b;
        b.pc    = pc;
        b.taken = outcome;
        branch_queue.push_back(b);
    endtask

    // ------------------------------------------------------------------
    // Driver: changes inputs on the falling edge. A request stays on the
    // ports until a rising edge sees start high and busy low. The sender
    // idles at 34% odds for the first third of the requests, at 71% for the
    // second third, and not at all for the last third.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : driver
        t_branch     nxt;
        int unsigned idle_pct;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || request_taken) begin
            if (issued_count < total_branches / 3) begin
                idle_pct = 34;
            end else if (issued_count < (2 * total_branches) / 3) begin
                idle_pct = 71;
            end else begin
                idle_pct = 0;
            end
            if (branch_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                nxt      = branch_queue.pop_front();
                start   <= 1'b1;
                i_pc    <= nxt.pc;
                i_taken <= nxt.taken;
                issued_count++;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: samples on the rising edge. The result strobe is checked
    // before an acceptance in the same cycle is recorded. The queue of
    // verdicts therefore stays in strict request order.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_verdict want;
        logic     accept;
        accept = i_rst_n && start && !busy;
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result strobe with no request outstanding");
            end else begin
                want = pending_verdicts.pop_front();
                if (o_predicted_taken !== want.predicted_taken) begin
                    report_mismatch($sformatf("request %0d predicted_taken %b, expected %b",
                        checked_count, o_predicted_taken, want.predicted_taken));
                end
                if (o_used_bimodal !== want.used_bimodal) begin
                    report_mismatch($sformatf("request %0d used_bimodal %b, expected %b",
                        checked_count, o_used_bimodal, want.used_bimodal));
                end
                if (o_mispredicted !== want.mispredicted) begin
                    report_mismatch($sformatf("request %0d mispredicted %b, expected %b",
                        checked_count, o_mispredicted, want.mispredicted));
                end
                mispredict_cnt += want.mispredicted;
                bimodal_cnt    += want.used_bimodal;
                checked_count++;
            end
        end
        if (accept) begin
            pending_verdicts.push_back(predict_and_train(i_pc, i_taken));
            accepted_count++;
        end
        request_taken <= accept;
    end

    // Watchdog: a hung handshake or a missing result ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, pending_verdicts.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [11:0]  habit_low    [HABIT_POOL];
        t_habit       habit_kind   [HABIT_POOL];
        int unsigned  habit_period [HABIT_POOL];
        int unsigned  habit_bias   [HABIT_POOL];
        int unsigned  habit_seq    [HABIT_POOL];
        int unsigned  k;
        int unsigned  n;
        logic         outcome;

        for (k = 0; k < GSHARE_N; k++) gshare_ctrs[k] = CTR_RESET;
        for (k = 0; k < BIMODAL_N; k++) bimodal_ctrs[k] = CTR_RESET;
        for (k = 0; k < CHOOSER_N; k++) chooser_ctrs[k] = CTR_RESET;
        global_hist = '0;

        // Directed part. Address zero is taken until its counters saturate
        // at the top. The all-ones address is then not taken until its
        // bimodal counter saturates at the bottom. The chooser picks gshare
        // for one of these and then settles back on bimodal.
        queue_branch(32'h0000_0000, 1'b1);
        queue_branch(32'h0000_0000, 1'b1);
        queue_branch(32'h0000_0000, 1'b1);
        queue_branch(32'h0000_0000, 1'b1);
        for (k = 0; k < 5; k++) queue_branch(32'hFFFF_FFFF, 1'b0);
        queue_branch(32'hFFFF_FFFF, 1'b1);
        // High address bits are ignored, so these alias onto address zero.
        queue_branch(32'h8000_0000, 1'b0);
        queue_branch(32'hFFFF_F000, 1'b0);
        // Same bimodal entry as address zero, but a different chooser entry.
        queue_branch(32'h0000_0400, 1'b0);
        queue_branch(32'h0000_0C00, 1'b1);
        // Alternating bit patterns in both polarities.
        queue_branch(32'h5555_5555, 1'b1);
        queue_branch(32'hAAAA_AAAA, 1'b0);
        queue_branch(32'h5555_5555, 1'b0);
        queue_branch(32'hAAAA_AAAA, 1'b1);
        // The history now holds a mix of outcomes. Repeat one address so
        // that the gshare index moves under it.
        for (k = 0; k < 4; k++) queue_branch(32'h0000_0123, k[0]);
        queue_branch(32'h7FFF_FFFF, 1'b1);

        // Random part. Most branches recur from a pool with fixed habits,
        // so counters saturate and the chooser swings both ways. Every
        // fourth pool entry shares its bimodal index with its neighbour.
        // The high address bits are fresh each time. The rest is noise.
        for (k = 0; k < HABIT_POOL; k++) begin
            habit_low[k]    = (k % 4 == 3) ? (habit_low[k-1] ^ 12'h400) : 12'($urandom);
            habit_kind[k]   = t_habit'($urandom_range(BIASED));
            habit_period[k] = $urandom_range(2, 7);
            habit_bias[k]   = $urandom_range(5, 95);
            habit_seq[k]    = 0;
        end
        for (n = 0; n < RANDOM_COUNT; n++) begin
            if ($urandom_range(99) < 15) begin
                queue_branch($urandom, 1'($urandom));
            end else begin
                k = $urandom_range(HABIT_POOL - 1);
                case (habit_kind[k])
                    ALWAYS_TAKEN: begin
                        outcome = 1'b1;
                    end
                    NEVER_TAKEN: begin
                        outcome = 1'b0;
                    end
                    ALTERNATING: begin
                        outcome = habit_seq[k][0];
                    end
                    LOOP_EXIT: begin
                        outcome = (habit_seq[k] % habit_period[k]) != habit_period[k] - 1;
                    end
                    default: begin
                        outcome = $urandom_range(99) < habit_bias[k];
                    end
                endcase
                habit_seq[k]++;
                queue_branch({20'($urandom), habit_low[k]}, outcome);
            end
        end
        total_branches = branch_queue.size();

        // Synchronous reset, released on a falling edge. The block then clears
        // its tables while busy.
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total_branches || pending_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d branch requests (%0d random): %0d mispredicted, %0d by bimodal.",
                 checked_count, RANDOM_COUNT, mispredict_cnt, bimodal_cnt);
        $display("Sender gaps ran at 34%%, then 71%%, then none; %0d mismatches in %0d cycles.",
                 error_count, cycle_count);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/tbp_pkg.sv
src/tbp_ctr_ram.sv
src/tbp_ctrl.sv
src/tournament_branch_predictor.sv
bench/testbench.sv
